// File: src/mwalu_pkg.sv
// Package: opcodes, width codes and helper functions for the multi-width ALU.
`timescale 1ns / 1ps
package mwalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_AND = 4'd1, OP_DIV = 4'd2, OP_MOD = 4'd3,
    OP_MUL = 4'd4, OP_NEG = 4'd5, OP_NOT = 4'd6, OP_OR  = 4'd7,
    OP_SHL = 4'd8, OP_SHR = 4'd9, OP_SUB = 4'd10, OP_XOR = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    SZ_8 = 2'd0, SZ_16 = 2'd1, SZ_19 = 2'd2, SZ_32 = 2'd3
  } size_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned QuotW  = 32;
  // One divider cell per quotient bit
  localparam int unsigned NCells = QuotW;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  size_a;
    logic [1:0]  size_b;
    logic [1:0]  size_result;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        cin;
  } alu_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        carry;
    logic        negative;
    logic        overflow;
    logic        zero;
  } alu_out_t;

  // Item context carried along the cell chain
  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  size_result;
    logic        sign_a;
    logic        sign_b;
    logic [63:0] v;          // precomputed value for non-divide operations
    logic [31:0] b;          // divisor
    logic [31:0] quot;       // quotient bits, shifted in at the bottom
    logic [32:0] rem;        // partial remainder
    logic [31:0] a;          // dividend, shifted out from the top
  } cell_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] m;
    unique case (size_e'(sz))
      SZ_8:    m = 32'h0000_00ff;
      SZ_16:   m = 32'h0000_ffff;
      SZ_19:   m = 32'h0007_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [31:0] x, input logic [1:0] sz);
    logic t;
    unique case (size_e'(sz))
      SZ_8:    t = x[7];
      SZ_16:   t = x[15];
      SZ_19:   t = x[18];
      default: t = x[31];
    endcase
    return t;
  endfunction

endpackage

// File: src/mwalu_if.sv
// Interface: valid/ready channel carrying one ALU item or one result item.
`timescale 1ns / 1ps
interface mwalu_in_if;
  import mwalu_pkg::*;
  logic    valid;
  logic    ready;
  alu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mwalu_out_if;
  import mwalu_pkg::*;
  logic     valid;
  logic     ready;
  alu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/multi_width_alu_with_flags_unit.sv
// Top level: front stage, chain of divider cells, back stage and output register.
// Path from the accepting edge to result valid: input reg, 32 cells, out reg.
// Throughput: one item per cycle; the divider is a chain of one-bit restoring cells.
// The whole chain stalls only when the output register is full and not taken.
// Reset: asynchronous active low clears all valid bits; no result is pending.
`timescale 1ns / 1ps
module multi_width_alu_with_flags_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  mwalu_in_if.sink        in_i,
  mwalu_out_if.source     out_o
);
  import mwalu_pkg::*;

  logic              adv;
  logic              in_vq, out_vq;
  cell_t             front_c, in_cq;
  cell_t             chain_c [NCells+1];
  logic              chain_v [NCells+1];
  alu_out_t          back_r, out_dq;

  // Chain moves unless the output holds a result that is not taken
  assign adv       = !out_vq || out_o.ready;
  assign in_i.ready = adv;

  mwalu_front u_front (.in_i(in_i.data), .cell_o(front_c));

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (adv) begin
      in_vq <= in_i.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_cq <= front_c;
    end
  end

  assign chain_v[0] = in_vq;
  assign chain_c[0] = in_cq;

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    mwalu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_v[g]),
      .cell_i  (chain_c[g]),
      .valid_o (chain_v[g+1]),
      .cell_o  (chain_c[g+1])
    );
  end

  mwalu_back u_back (.cell_i(chain_c[NCells]), .out_o(back_r));

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv) begin
      out_vq <= chain_v[NCells];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_dq <= back_r;
    end
  end

  assign out_o.valid = out_vq;
  assign out_o.data  = out_dq;

  // Held result stays put while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && !out_o.ready |=> out_vq && $stable(out_dq))
    else $error("result changed while stalled");

  // Zero flag agrees with the result
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq |-> (out_dq.zero == (out_dq.result == 32'd0)))
    else $error("zero flag mismatch");

  // A result reading zero with carry and overflow set, as after divide by zero, has negative clear
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && out_dq.overflow && out_dq.carry && out_dq.zero |-> !out_dq.negative)
    else $error("divide by zero flags inconsistent");
endmodule

// File: src/mwalu_front.sv
// Front stage: mask operands, compute the non-divide value and seed the chain.
`timescale 1ns / 1ps
module mwalu_front (
  input  mwalu_pkg::alu_in_t in_i,
  output mwalu_pkg::cell_t   cell_o
);
  import mwalu_pkg::*;

  logic [31:0] a, b;
  logic [63:0] a64, b64, v;

  assign a   = in_i.operand_a & size_mask(in_i.size_a);
  assign b   = in_i.operand_b & size_mask(in_i.size_b);
  assign a64 = {32'd0, a};
  assign b64 = {32'd0, b};

  // Select value for every operation except divide and modulo
  always_comb begin
    unique case (in_i.command)
      OP_ADD:  v = a64 + b64 + {63'd0, in_i.cin};
      OP_AND:  v = a64 & b64;
      OP_MUL:  v = a64 * b64;
      OP_NEG:  v = 64'd0 - a64;
      OP_NOT:  v = ~a64;
      OP_OR:   v = a64 | b64;
      OP_SHL:  v = a64 << b[5:0];
      OP_SHR:  v = a64 >> b[5:0];
      OP_SUB:  v = a64 - b64 + {63'd0, in_i.cin};
      OP_XOR:  v = a64 ^ b64;
      default: v = 64'd0;
    endcase
  end

  always_comb begin
    cell_o.command     = in_i.command;
    cell_o.size_result = in_i.size_result;
    cell_o.sign_a      = top_bit(a, in_i.size_a);
    cell_o.sign_b      = top_bit(b, in_i.size_b);
    cell_o.v           = v;
    cell_o.b           = b;
    cell_o.quot        = '0;
    cell_o.rem         = '0;
    cell_o.a           = a;
  end
endmodule

// File: src/mwalu_cell.sv
// Divider cell: one restoring step per cycle while the chain advances, registered hand-off to the next cell.
`timescale 1ns / 1ps
module mwalu_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mwalu_pkg::cell_t  cell_i,
  output logic              valid_o,
  output mwalu_pkg::cell_t  cell_o
);
  import mwalu_pkg::*;

  logic            valid_q;
  cell_t           cell_q, cell_d;
  logic [32:0]     trial, diff;

  // Shift in next dividend bit and try subtract
  always_comb begin
    trial  = {cell_i.rem[31:0], cell_i.a[31]};
    diff   = trial - {1'b0, cell_i.b};
    cell_d = cell_i;
    cell_d.a    = {cell_i.a[30:0], 1'b0};
    cell_d.quot = {cell_i.quot[30:0], ~diff[32]};
    cell_d.rem  = diff[32] ? trial : diff;
  end

  // Advance when the chain moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;
endmodule

// File: src/mwalu_back.sv
// Back stage: pick the final value, adjust negatives and derive the flags.
`timescale 1ns / 1ps
module mwalu_back (
  input  mwalu_pkg::cell_t    cell_i,
  output mwalu_pkg::alu_out_t out_o
);
  import mwalu_pkg::*;

  logic        is_div, dz;
  logic [63:0] v, va, wbit;
  logic [31:0] m, r;
  logic        neg, carry, ovf;

  always_comb begin
    is_div = (cell_i.command == OP_DIV) || (cell_i.command == OP_MOD);
    dz     = is_div && (cell_i.b == 32'd0);
    m      = size_mask(cell_i.size_result);
    unique case (size_e'(cell_i.size_result))
      SZ_8:    wbit = 64'd1 << 8;
      SZ_16:   wbit = 64'd1 << 16;
      SZ_19:   wbit = 64'd1 << 19;
      default: wbit = 64'd1 << 32;
    endcase
    if (dz) begin
      v = 64'd0;
    end else if (cell_i.command == OP_DIV) begin
      v = {32'd0, cell_i.quot};
    end else if (cell_i.command == OP_MOD) begin
      v = {32'd0, cell_i.rem[31:0]};
    end else begin
      v = cell_i.v;
    end
    // Add 2^w to a negative value
    va    = v[63] ? v + wbit : v;
    r     = va[31:0] & m;
    neg   = top_bit(va[31:0], cell_i.size_result);
    carry = dz || ((cell_i.command == OP_SUB) && v[63])
            || ((va & ~{32'd0, m}) != 64'd0);
    ovf   = dz;
    if ((cell_i.command == OP_ADD) || (cell_i.command == OP_MUL)) begin
      ovf = (cell_i.sign_a == cell_i.sign_b) && (cell_i.sign_a != neg);
    end else if (cell_i.command == OP_SUB) begin
      ovf = (cell_i.sign_a != cell_i.sign_b) && (cell_i.sign_a != neg);
    end
    out_o.result   = r;
    out_o.carry    = carry;
    out_o.negative = neg;
    out_o.overflow = ovf;
    out_o.zero     = (r == 32'd0);
  end
endmodule

// File: sim/multi_width_alu_with_flags_unit_tb.sv
// Testbench for the multi-width ALU: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module multi_width_alu_with_flags_unit_tb;
  import mwalu_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   err_cnt = 0;
  bit   idle_en = 1'b1;
  alu_out_t want_q[$];

  mwalu_in_if  in_if ();
  mwalu_out_if out_if ();

  multi_width_alu_with_flags_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Width in bits for a size code
  function automatic int unsigned size_bits(input logic [1:0] sz);
    case (size_e'(sz))
      SZ_8:    return 8;
      SZ_16:   return 16;
      SZ_19:   return 19;
      default: return 32;
    endcase
  endfunction

  // Compute the result and flags of one ALU item
  function automatic alu_out_t alu_predict(input alu_in_t it);
    logic [63:0] a, b, v, wmask;
    logic        sa, sb, c, ov, ng;
    int unsigned wa, wb, wr;
    alu_out_t    r;
    wa = size_bits(it.size_a);
    wb = size_bits(it.size_b);
    wr = size_bits(it.size_result);
    a = {32'd0, it.operand_a} & ((64'd1 << wa) - 1);
    b = {32'd0, it.operand_b} & ((64'd1 << wb) - 1);
    wmask = (64'd1 << wr) - 1;
    sa = a[wa-1];
    sb = b[wb-1];
    c = 1'b0;
    ov = 1'b0;
    v = '0;
    case (it.command)
      OP_ADD: v = a + b + it.cin;
      OP_AND: v = a & b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          c = 1'b1;
          ov = 1'b1;
        end else begin
          v = (it.command == OP_DIV) ? a / b : a % b;
        end
      end
      OP_MUL: v = a * b;
      OP_NEG: v = 64'd0 - a;
      OP_NOT: v = ~a;
      OP_OR:  v = a | b;
      OP_SHL: v = a << b[5:0];
      OP_SHR: v = a >> b[5:0];
      OP_SUB: begin
        v = a - b + it.cin;
        c = v[63];
      end
      OP_XOR: v = a ^ b;
      default: v = '0;
    endcase
    if (v[63]) v = v + (64'd1 << wr);
    ng = v[wr-1];
    if ((v & ~wmask) != 0) c = 1'b1;
    if (it.command == OP_ADD || it.command == OP_MUL) begin
      if (sa == sb && sa != ng) ov = 1'b1;
    end else if (it.command == OP_SUB) begin
      if (sa != sb && sa != ng) ov = 1'b1;
    end
    v = v & wmask;
    r.result = v[31:0];
    r.carry = c;
    r.negative = ng;
    r.overflow = ov;
    r.zero = (v == 0);
    return r;
  endfunction

  // Send one item, with an optional idle burst first
  task automatic send_item(input alu_in_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_if.data  <= it;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    want_q.push_back(alu_predict(it));
    @(negedge clk_i);
  endtask

  function automatic alu_in_t make_item(input logic [3:0] cmd, input logic [1:0] s_a,
                                        input logic [1:0] s_b, input logic [1:0] s_r,
                                        input logic [31:0] a, input logic [31:0] b,
                                        input logic cin);
    alu_in_t it;
    it = '{cmd, s_a, s_b, s_r, a, b, cin};
    return it;
  endfunction

  // Random operand, biased to edge values
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return $urandom_range(0, 3);
      3:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Every opcode at the widest width, then an add at the narrowest width and a mixed-width multiply
  task automatic test_every_op();
    for (int op = 0; op < 16; op++) begin
      send_item(make_item(4'(op), SZ_32, SZ_32, SZ_32, 32'hffff_ffff, 32'h8000_0001, 1'b1));
    end
    send_item(make_item(OP_ADD, SZ_8, SZ_8, SZ_8, 32'h7f, 32'h01, 1'b0));
    send_item(make_item(OP_MUL, SZ_19, SZ_16, SZ_16, 32'h7_ffff, 32'hffff, 1'b0));
  endtask

  // Divide and modulo by zero, negative subtract, wide left shifts, wide right shift, negate of zero
  task automatic test_special_cases();
    send_item(make_item(OP_DIV, SZ_32, SZ_8, SZ_32, 32'h1234, 32'hff00, 1'b0));
    send_item(make_item(OP_MOD, SZ_16, SZ_19, SZ_8, 32'h55, 32'h0, 1'b1));
    send_item(make_item(OP_SUB, SZ_8, SZ_32, SZ_19, 32'h3, 32'h10, 1'b0));
    send_item(make_item(OP_SHL, SZ_32, SZ_8, SZ_32, 32'h8000_0000, 32'd31, 1'b0));
    send_item(make_item(OP_SHL, SZ_32, SZ_8, SZ_8, 32'hffff_ffff, 32'd63, 1'b0));
    send_item(make_item(OP_SHR, SZ_32, SZ_8, SZ_16, 32'hffff_ffff, 32'd40, 1'b0));
    send_item(make_item(OP_NEG, SZ_8, SZ_8, SZ_32, 32'h0, 32'h0, 1'b0));
  endtask

  // Random items over every field
  task automatic test_random(input int n);
    alu_in_t it;
    for (int i = 0; i < n; i++) begin
      it.command     = 4'($urandom_range(0, 15));
      it.size_a      = 2'($urandom_range(0, 3));
      it.size_b      = 2'($urandom_range(0, 3));
      it.size_result = 2'($urandom_range(0, 3));
      it.operand_a   = rand_operand();
      it.operand_b   = rand_operand();
      it.cin         = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  // Result sink: random stalls while idling is enabled
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    alu_out_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result %h", out_if.data);
        err_cnt++;
      end else begin
        w = want_q.pop_front();
        if (out_if.data.result !== w.result) begin
          $error("result: expected %h actual %h", w.result, out_if.data.result);
          err_cnt++;
        end
        if (out_if.data.carry !== w.carry) begin
          $error("carry: expected %b actual %b", w.carry, out_if.data.carry);
          err_cnt++;
        end
        if (out_if.data.negative !== w.negative) begin
          $error("negative: expected %b actual %b", w.negative, out_if.data.negative);
          err_cnt++;
        end
        if (out_if.data.overflow !== w.overflow) begin
          $error("overflow: expected %b actual %b", w.overflow, out_if.data.overflow);
          err_cnt++;
        end
        if (out_if.data.zero !== w.zero) begin
          $error("zero: expected %b actual %b", w.zero, out_if.data.zero);
          err_cnt++;
        end
      end
    end
  end

  // Run the tests in turn
  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_every_op();
    test_special_cases();
    test_random(500);
    idle_en = 1'b0;
    test_random(100);
    in_if.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (NCells + 10) @(posedge clk_i);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
